/* rtl/length_prefixed_frame_splitter_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame splitter
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_SPLITTER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define LPFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfs: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define LPFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfs: next-cycle check failed");

`endif

/* rtl/lpfs_pkg.sv */
// ----------------------------------------------------------------------------
// Frame splitter package
// Widths, reset values, result kinds and the item type between the stages.
// ----------------------------------------------------------------------------
package lpfs_pkg;

  // Default header layout: length bytes, then command bytes
  localparam int unsigned LenBytesDef = 4;
  localparam int unsigned CmdBytesDef = 4;

  // Maximum frame length register
  localparam int unsigned MaxLenW        = 17;
  localparam logic [MaxLenW-1:0] MaxLenRst = 17'h10000;

  localparam int unsigned CmdW  = 32;
  localparam int unsigned ByteW = 8;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BADLEN  = 2'd2
  } kind_e;

  // Registered input item handed to the core
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
  } in_item_t;

endpackage

/* rtl/length_prefixed_frame_splitter_top.sv */
// Length-prefixed frame splitter: takes one received byte per cycle while
// in_stall_o is low; a byte passes through the input register and then the
// result register around the single-pass header/payload
// logic. Each frame opens with a little-endian signed total length
// (LEN_BYTES) and a command word (CMD_BYTES); payload bytes then come out one
// per result tagged with the command, the last one marked. An empty payload
// gives one empty-frame result; a length below the header size, negative, or
// at or above max_frame_len gives a bad-length result and gathering restarts
// with the next byte. max_frame_len is written through cfg_we_i/cfg_wdata_i.
// ----------------------------------------------------------------------------
// Frame splitter top level
// Input register stage followed by the deframing core with its result register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_splitter_top
  import lpfs_pkg::*;
#(
  parameter int unsigned LEN_BYTES = LenBytesDef,
  parameter int unsigned CMD_BYTES = CmdBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MaxLenW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [CmdW-1:0]    command_o,
  output logic               last_of_frame_o
);

  in_item_t item;
  logic     take;

  // Input register
  lpfs_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .take_i      (take),
    .item_o      (item)
  );

  // Deframing core
  lpfs_core #(
    .LEN_BYTES (LEN_BYTES),
    .CMD_BYTES (CMD_BYTES)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .item_i          (item),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .command_o       (command_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

/* rtl/lpfs_in_stage.sv */
// ----------------------------------------------------------------------------
// Frame splitter input register
// Holds one received byte until the core takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module lpfs_in_stage
  import lpfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             take_i,
  output in_item_t         item_o
);

  logic             vld_q;
  logic [ByteW-1:0] data_q;

  // Stall only while a held item is not being taken
  assign in_stall_o = vld_q && !take_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Data, no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= data_byte_i;
    end
  end

  assign item_o.vld  = vld_q;
  assign item_o.data = data_q;

endmodule

/* rtl/lpfs_core.sv */
// ----------------------------------------------------------------------------
// Frame splitter core
// Header gathering, length check, payload countdown and the result register.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_splitter_top_macros.svh"

module lpfs_core
  import lpfs_pkg::*;
#(
  parameter int unsigned LEN_BYTES = LenBytesDef,
  parameter int unsigned CMD_BYTES = CmdBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MaxLenW-1:0] cfg_wdata_i,
  input  in_item_t           item_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [CmdW-1:0]    command_o,
  output logic               last_of_frame_o
);

  localparam int unsigned Hdr   = LEN_BYTES + CMD_BYTES;
  localparam int unsigned HdrW  = 8 * Hdr;
  localparam int unsigned LenW  = 8 * LEN_BYTES;
  localparam int unsigned CmdBW = 8 * CMD_BYTES;
  localparam int unsigned CntW  = $clog2(Hdr);

  // State
  logic [MaxLenW-1:0] max_q;
  logic [HdrW-1:0]    hdr_q, hdr_d, hdr_nxt;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               inpay_q, inpay_d;
  logic [MaxLenW-1:0] rem_q, rem_d;
  logic [CmdW-1:0]    cmd_q, cmd_d;

  // Result register
  logic               out_vld_q;
  kind_e              kind_q;
  logic [ByteW-1:0]   pbyte_q;
  logic [CmdW-1:0]    rcmd_q;
  logic               last_q;

  logic               out_free;
  logic               fire;
  logic               res_vld;
  kind_e              res_kind;
  logic [ByteW-1:0]   res_byte;
  logic [CmdW-1:0]    res_cmd;
  logic               res_last;

  logic [LenW-1:0]    len_raw;
  logic [31:0]        len32;
  logic [CmdW-1:0]    hdr_cmd;
  logic               len_bad;

  // Take a byte whenever the result slot is free or draining
  assign out_free = !out_vld_q || !out_stall_i;
  assign take_o   = out_free;
  assign fire     = item_i.vld && out_free;

  // Header with the current byte dropped in
  always_comb begin
    hdr_nxt = hdr_q;
    hdr_nxt[cnt_q*8 +: 8] = item_i.data;
  end

  // Header decode: little-endian length, then command
  assign len_raw = hdr_nxt[LenW-1:0];
  assign len32   = 32'(len_raw);
  assign hdr_cmd = CmdW'(hdr_nxt[HdrW-1 -: CmdBW]);
  assign len_bad = len_raw[LenW-1] || (len32 < 32'(Hdr)) || (len32 >= 32'(max_q));

  // Next state and result
  always_comb begin
    hdr_d    = hdr_q;
    cnt_d    = cnt_q;
    inpay_d  = inpay_q;
    rem_d    = rem_q;
    cmd_d    = cmd_q;
    res_vld  = 1'b0;
    res_kind = KIND_PAYLOAD;
    res_byte = '0;
    res_cmd  = cmd_q;
    res_last = 1'b0;
    if (fire) begin
      if (inpay_q) begin
        // Payload byte, tagged with the frame's command
        res_vld  = 1'b1;
        res_byte = item_i.data;
        res_last = (rem_q <= MaxLenW'(1));
        if (res_last) begin
          inpay_d = 1'b0;
          rem_d   = '0;
        end else begin
          rem_d = rem_q - MaxLenW'(1);
        end
      end else begin
        hdr_d = hdr_nxt;
        if (cnt_q == CntW'(Hdr - 1)) begin
          // Header complete
          cnt_d   = '0;
          cmd_d   = hdr_cmd;
          res_cmd = hdr_cmd;
          if (len_bad) begin
            res_vld  = 1'b1;
            res_kind = KIND_BADLEN;
            res_last = 1'b1;
          end else if (len32 == 32'(Hdr)) begin
            res_vld  = 1'b1;
            res_kind = KIND_EMPTY;
            res_last = 1'b1;
          end else begin
            inpay_d = 1'b1;
            rem_d   = MaxLenW'(len32 - 32'(Hdr));
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= MaxLenRst;
      cnt_q     <= '0;
      inpay_q   <= 1'b0;
      rem_q     <= '0;
      cmd_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      cnt_q   <= cnt_d;
      inpay_q <= inpay_d;
      rem_q   <= rem_d;
      cmd_q   <= cmd_d;
      if (out_free) begin
        out_vld_q <= res_vld;
      end
    end
  end

  // Header bytes and result payload, no reset
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (out_free && res_vld) begin
      kind_q  <= res_kind;
      pbyte_q <= res_byte;
      rcmd_q  <= res_cmd;
      last_q  <= res_last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = pbyte_q;
  assign command_o       = rcmd_q;
  assign last_of_frame_o = last_q;

  // Checks
  `LPFS_ASSERT_IMP(a_ctrl_ends_frame, clk_i, rst_ni, out_vld_q && (kind_q != KIND_PAYLOAD), last_q && (pbyte_q == '0))
  `LPFS_ASSERT_IMP(a_payload_count, clk_i, rst_ni, inpay_q, (rem_q != '0) && (cnt_q == '0))
  `LPFS_ASSERT_NXT(a_frame_end_rearms, clk_i, rst_ni, fire && inpay_q && (rem_q <= MaxLenW'(1)), !inpay_q)

endmodule
